[rtl/io_port_permission_bitmap_macros.svh]
// Assertion macros for the I/O port permission bitmap.
`ifndef IO_PORT_PERMISSION_BITMAP_MACROS_SVH
`define IO_PORT_PERMISSION_BITMAP_MACROS_SVH

`ifndef SYNTH
`define IOPB_ASSERT_NOW(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("iopb assertion failed");
`define IOPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iopb assertion failed");
`else
`define IOPB_ASSERT_NOW(lbl, clk, rst_n, cond)
`define IOPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/iopb_pkg.sv]
// Package with operation codes, status codes and types of the permission bitmap.
`default_nettype none

package iopb_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int PORT_W   = 16;
    localparam int COUNT_W  = 17;
    localparam int BYTE_W   = 8;
    localparam int BIDX_W   = 3;
    localparam int BADDR_W  = PORT_W - BIDX_W;
    localparam int MAX_BYTES = 1 << BADDR_W;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [BYTE_W-1:0]  BYTE_ONES = '1;

    typedef enum logic {
        CLR_SWEEP,
        CLR_DONE
    } t_clr_state;

endpackage

`default_nettype wire

[rtl/io_port_permission_bitmap.sv]
// The input transfer reads memory into the update stage, whose result is registered out.
// Throughput: one item per cycle; a write to the byte read the cycle before is forwarded.
// Rate holds unless out_ready stalls or the sweep runs; memory is one-read, one-write.
// Reset: synchronous, active low; page flags and count clear at once, then a sweep
// fills the bitmap memory with ones, one byte per cycle (8192 bytes by default),
// with o_in_ready low until it ends.
`default_nettype none
`include "io_port_permission_bitmap_macros.svh"

module io_port_permission_bitmap #(
    parameter int PORT_TOTAL = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [iopb_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [iopb_pkg::PORT_W-1:0]    i_port,
    input  wire logic                           i_page_available,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [iopb_pkg::STATUS_W-1:0]  o_status,
    output logic                                o_enabled,
    output logic      [iopb_pkg::COUNT_W-1:0]   o_port_count
);
    import iopb_pkg::*;

    localparam int BMAP_BYTES = (PORT_TOTAL + 7) / 8;
    localparam int DEPTH      = (BMAP_BYTES < MAX_BYTES) ? BMAP_BYTES : MAX_BYTES;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PG_N       = (DEPTH + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int PGW        = (PG_N > 1) ? $clog2(PG_N) : 1;
    localparam int PBW        = $clog2(PAGE_BYTES);
    localparam int RK         = BADDR_W + PBW;
    localparam int MW         = BADDR_W + 1;
    localparam longint RECIP  = ((64'd1 << RK) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int PW         = BADDR_W + MW + PGW;
    localparam int CMP_W      = 21;
    localparam logic [CMP_W-1:0]  PORT_LIM = CMP_W'(PORT_TOTAL);
    localparam logic [MW-1:0]     RECIP_L  = MW'(RECIP);

    // input stage
    logic                 w_in_xfer;
    logic                 w_s1_adv;
    logic                 w_busy;
    logic                 w_clr_wr;
    logic [AW-1:0]        w_clr_addr;
    logic [BADDR_W-1:0]   w_byte;
    logic [PW-1:0]        w_prod;
    logic                 w_in_range;

    // update stage
    logic                 r_s1_valid;
    logic [FUNC_W-1:0]    r_s1_func;
    logic [AW-1:0]        r_s1_addr;
    logic [BIDX_W-1:0]    r_s1_bit;
    logic [PGW-1:0]       r_s1_page;
    logic                 r_s1_in_range;
    logic                 r_s1_avail;

    logic                 r_fw_valid;
    logic [AW-1:0]        r_fw_addr;
    logic [BYTE_W-1:0]    r_fw_data;

    logic                 r_page_map [PG_N];
    logic [COUNT_W-1:0]   r_count;

    logic [BYTE_W-1:0]    w_rd_data;
    logic [BYTE_W-1:0]    w_cur;
    logic [BYTE_W-1:0]    w_mask;
    logic                 w_mapped;
    logic                 w_is_en;
    logic                 w_wr_need;
    logic                 w_s1_wr;
    logic                 w_map_need;
    logic [BYTE_W-1:0]    w_new_byte;
    logic [COUNT_W-1:0]   w_new_count;
    logic [STATUS_W-1:0]  w_status;
    logic                 w_enabled;

    logic                 w_mem_wr_en;
    logic [AW-1:0]        w_mem_wr_addr;
    logic [BYTE_W-1:0]    w_mem_wr_data;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic                 r_out_enabled;
    logic [COUNT_W-1:0]   r_out_count;

    iopb_clear #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_clear (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (w_busy),
        .o_wr_en   (w_clr_wr),
        .o_wr_addr (w_clr_addr)
    );

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !w_busy && (!r_s1_valid || w_s1_adv);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_byte     = i_port[PORT_W-1:BIDX_W];
    assign w_in_range = ({(CMP_W - PORT_W)'(0), i_port} < PORT_LIM);
    assign w_prod     = PW'(w_byte) * PW'(RECIP_L);

    iopb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_xfer),
        .i_rd_addr (w_byte[AW-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_func     <= i_func;
            r_s1_addr     <= w_byte[AW-1:0];
            r_s1_bit      <= i_port[BIDX_W-1:0];
            r_s1_page     <= w_prod[RK +: PGW];
            r_s1_in_range <= w_in_range;
            r_s1_avail    <= i_page_available;
        end
    end

    always_comb begin
        w_cur       = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : w_rd_data;
        w_mask      = BYTE_W'(1) << r_s1_bit;
        w_mapped    = r_s1_in_range && r_page_map[r_s1_page];
        w_is_en     = w_mapped && ((w_cur & w_mask) == '0);
        w_wr_need   = 1'b0;
        w_map_need  = 1'b0;
        w_new_byte  = w_cur;
        w_new_count = r_count;
        w_status    = ST_OK;
        w_enabled   = 1'b0;
        case (r_s1_func)
            FN_INSERT: begin
                if (!r_s1_in_range || (!w_mapped && !r_s1_avail)) begin
                    w_status = ST_NOMEM;
                end else begin
                    w_map_need = !w_mapped;
                    w_enabled  = 1'b1;
                    if (w_is_en) begin
                        w_status = ST_EXISTS;
                    end else begin
                        w_wr_need  = 1'b1;
                        w_new_byte = w_cur & ~w_mask;
                        if (r_count != COUNT_MAX) begin
                            w_new_count = r_count + COUNT_W'(1);
                        end
                    end
                end
            end
            FN_DELETE: begin
                if (w_is_en) begin
                    w_wr_need  = 1'b1;
                    w_new_byte = w_cur | w_mask;
                    if (r_count != '0) begin
                        w_new_count = r_count - COUNT_W'(1);
                    end
                end
            end
            default: begin
                w_enabled = w_is_en;
            end
        endcase
    end

    assign w_s1_wr = w_s1_adv && w_wr_need;

    assign w_mem_wr_en   = w_clr_wr || w_s1_wr;
    assign w_mem_wr_addr = w_clr_wr ? w_clr_addr : r_s1_addr;
    assign w_mem_wr_data = w_clr_wr ? BYTE_ONES : w_new_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PG_N; i++) begin
                r_page_map[i] <= 1'b0;
            end
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_fw_valid <= w_wr_need;
                r_count    <= w_new_count;
                if (w_map_need) begin
                    r_page_map[r_s1_page] <= 1'b1;
                end
            end
            r_out_valid <= w_s1_adv || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_fw_addr     <= r_s1_addr;
            r_fw_data     <= w_new_byte;
            r_out_status  <= w_status;
            r_out_enabled <= w_enabled;
            r_out_count   <= w_new_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_enabled    = r_out_enabled;
    assign o_port_count = r_out_count;

    `IOPB_ASSERT_NOW(a_one_writer, i_clk, i_rst_n, !(w_clr_wr && w_s1_wr))
    `IOPB_ASSERT_NOW(a_sweep_idle, i_clk, i_rst_n, !w_busy || (!r_s1_valid && !r_fw_valid))
    `IOPB_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, !w_s1_adv, $stable(r_count))
    `IOPB_ASSERT_NXT(a_map_on_write, i_clk, i_rst_n, w_s1_wr, r_page_map[$past(r_s1_page)])

endmodule

`default_nettype wire

[rtl/iopb_ram.sv]
// Single write port, single registered read port bitmap memory.
`default_nettype none

module iopb_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic      [iopb_pkg::BYTE_W-1:0] o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [iopb_pkg::BYTE_W-1:0] i_wr_data
);
    import iopb_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/iopb_clear.sv]
// Post-reset sweep that fills the bitmap memory with ones.
`default_nettype none

module iopb_clear #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    output logic               o_busy,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr
);
    import iopb_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_clr_state    r_state;
    t_clr_state    n_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            CLR_SWEEP: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = CLR_DONE;
                end
            end
            CLR_DONE: begin
                n_state = CLR_DONE;
            end
            default: begin
                n_state = CLR_SWEEP;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            CLR_SWEEP: begin
                o_busy  = 1'b1;
                o_wr_en = 1'b1;
            end
            default: begin
                o_busy  = 1'b0;
                o_wr_en = 1'b0;
            end
        endcase
        o_wr_addr = r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CLR_SWEEP;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the I/O port permission bitmap against a shadow copy of its state.
module tb;
    import iopb_pkg::*;

    localparam int PORT_TOTAL = 65536;
    localparam int PAGE_BYTES = 4096;
    localparam int BMAP_BYTES = (PORT_TOTAL + 7) / 8;
    localparam int PAGE_COUNT = (BMAP_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int HOT_PORTS = 40;
    localparam int RANDOM_MAIN = 1550;
    localparam int RANDOM_TAIL = 150;
    localparam int LONG_HOLD = 60;
    localparam int LONG_HOLD_AT = 300;
    localparam int TAIL_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [PORT_W-1:0] port;
        logic              avail;
    } t_port_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                enabled;
        logic [COUNT_W-1:0]  count;
    } t_port_resp;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func = '0;
    logic [PORT_W-1:0]   port = '0;
    logic                page_avail = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                enabled;
    logic [COUNT_W-1:0]  port_count;

    logic [BYTE_W-1:0]  shadow_bits [BMAP_BYTES];
    logic               shadow_mapped [PAGE_COUNT];
    logic [COUNT_W-1:0] shadow_count;
    logic [PORT_W-1:0]  hot_ports [HOT_PORTS];

    t_port_req  pending_reqs [$];
    t_port_resp expected_resp [$];
    t_port_req  next_req;
    t_port_req  taken_req;
    t_port_resp predicted;
    t_port_resp want;

    logic in_taken = 1'b0;
    logic quiet_tail = 1'b0;
    logic long_hold_done = 1'b0;
    int   send_gap = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   op_tally [4] = '{0, 0, 0, 0};
    int   exists_seen = 0;
    int   nomem_seen = 0;
    logic [COUNT_W-1:0] peak_count = '0;

    io_port_permission_bitmap #(
        .PORT_TOTAL(PORT_TOTAL),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_func(func),
        .i_port(port),
        .i_page_available(page_avail),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_status(status),
        .o_enabled(enabled),
        .o_port_count(port_count)
    );

    always #1 clk = ~clk;

    function automatic t_port_resp apply_port_op(t_port_req req);
        t_port_resp        resp;
        int unsigned       byte_idx;
        int unsigned       page_idx;
        logic [BYTE_W-1:0] mask;
        logic              mapped;
        logic              was_en;
        resp.status = ST_OK;
        resp.enabled = 1'b0;
        if (int'(req.port) < PORT_TOTAL) begin
            byte_idx = req.port >> BIDX_W;
            page_idx = byte_idx / PAGE_BYTES;
            mask = BYTE_W'(1) << req.port[BIDX_W-1:0];
            mapped = shadow_mapped[page_idx];
            was_en = mapped && ((shadow_bits[byte_idx] & mask) == '0);
            case (req.fn)
                FN_INSERT: begin
                    if (!mapped && !req.avail) begin
                        resp.status = ST_NOMEM;
                    end else begin
                        shadow_mapped[page_idx] = 1'b1;
                        if (was_en) begin
                            resp.status = ST_EXISTS;
                        end else begin
                            shadow_bits[byte_idx] = shadow_bits[byte_idx] & ~mask;
                            if (shadow_count != COUNT_MAX) begin
                                shadow_count = shadow_count + 1'b1;
                            end
                        end
                        resp.enabled = 1'b1;
                    end
                end
                FN_DELETE: begin
                    if (was_en) begin
                        shadow_bits[byte_idx] = shadow_bits[byte_idx] | mask;
                        if (shadow_count != '0) begin
                            shadow_count = shadow_count - 1'b1;
                        end
                    end
                end
                default: begin
                    resp.enabled = was_en;
                end
            endcase
        end else if (req.fn == FN_INSERT) begin
            resp.status = ST_NOMEM;
        end
        resp.count = shadow_count;
        return resp;
    endfunction

    function automatic t_port_req random_req();
        t_port_req   req;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            req.fn = FN_INSERT;
        end else if (pick < 14) begin
            req.fn = FN_DELETE;
        end else if (pick < 19) begin
            req.fn = FN_LOOKUP;
        end else begin
            req.fn = FN_UNUSED;
        end
        if ($urandom_range(0, 3) != 0) begin
            req.port = hot_ports[$urandom_range(0, HOT_PORTS - 1)];
        end else begin
            req.port = PORT_W'($urandom_range(0, 65535));
        end
        req.avail = ($urandom_range(0, 7) != 0);
        return req;
    endfunction

    task automatic queue_req(input logic [FUNC_W-1:0] fn, input int p,
                             input logic avail);
        t_port_req req;
        req.fn = fn;
        req.port = PORT_W'(p);
        req.avail = avail;
        pending_reqs.push_back(req);
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_taken || !in_valid) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                in_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 9);
                in_valid <= 1'b0;
            end else begin
                next_req = pending_reqs.pop_front();
                func <= next_req.fn;
                port <= next_req.port;
                page_avail <= next_req.avail;
                in_valid <= 1'b1;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                taken_req = {func, port, page_avail};
                predicted = apply_port_op(taken_req);
                expected_resp.push_back(predicted);
                op_tally[func]++;
                if (predicted.status == ST_EXISTS) begin
                    exists_seen++;
                end
                if (predicted.status == ST_NOMEM) begin
                    nomem_seen++;
                end
                if (predicted.count > peak_count) begin
                    peak_count = predicted.count;
                end
            end
            if (out_valid && out_ready) begin
                if (expected_resp.size() == 0) begin
                    $error("unexpected result: status %0d enabled %0d port_count %0d",
                           status, enabled, port_count);
                    fail_count++;
                end else begin
                    want = expected_resp.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (enabled !== want.enabled) begin
                        $error("enabled: expected %0d, got %0d", want.enabled, enabled);
                        fail_count++;
                    end
                    if (port_count !== want.count) begin
                        $error("port_count: expected %0d, got %0d", want.count, port_count);
                        fail_count++;
                    end
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer in %0d cycles", WATCHDOG_LIMIT);
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < BMAP_BYTES; i++) begin
            shadow_bits[i] = BYTE_ONES;
        end
        for (int i = 0; i < PAGE_COUNT; i++) begin
            shadow_mapped[i] = 1'b0;
        end
        shadow_count = '0;

        hot_ports[0] = 16'd0;
        hot_ports[1] = 16'd7;
        hot_ports[2] = 16'd8;
        hot_ports[3] = 16'd32767;
        hot_ports[4] = 16'd32768;
        hot_ports[5] = 16'd65535;
        begin
            int unsigned base;
            base = $urandom_range(0, BMAP_BYTES - 1) * 8;
            for (int i = 6; i < 14; i++) begin
                hot_ports[i] = PORT_W'(base + i - 6);
            end
        end
        for (int i = 14; i < HOT_PORTS; i++) begin
            hot_ports[i] = PORT_W'($urandom_range(0, 65535));
        end

        queue_req(FN_LOOKUP, 0, 1'b1);
        queue_req(FN_INSERT, 0, 1'b0);
        queue_req(FN_INSERT, 65535, 1'b0);
        queue_req(FN_DELETE, 0, 1'b1);
        queue_req(FN_UNUSED, 65535, 1'b1);
        queue_req(FN_LOOKUP, 40000, 1'b0);
        queue_req(FN_INSERT, 0, 1'b1);
        queue_req(FN_INSERT, 0, 1'b0);
        queue_req(FN_LOOKUP, 0, 1'b0);
        queue_req(FN_INSERT, 7, 1'b0);
        queue_req(FN_INSERT, 32767, 1'b0);
        queue_req(FN_INSERT, 32768, 1'b0);
        queue_req(FN_INSERT, 65535, 1'b1);
        queue_req(FN_INSERT, 32768, 1'b0);
        queue_req(FN_UNUSED, 0, 1'b0);
        queue_req(FN_DELETE, 7, 1'b0);
        queue_req(FN_DELETE, 7, 1'b1);
        queue_req(FN_LOOKUP, 7, 1'b1);
        queue_req(FN_DELETE, 0, 1'b0);
        queue_req(FN_INSERT, 0, 1'b0);
        queue_req(FN_LOOKUP, 1, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait until every directed result is back before queueing random requests
        do begin
            @(posedge clk) #0.5;
        end while (pending_reqs.size() != 0 || in_valid || expected_resp.size() != 0);
        for (int i = 0; i < RANDOM_MAIN; i++) begin
            pending_reqs.push_back(random_req());
        end

        do begin
            @(posedge clk) #0.5;
        end while (pending_reqs.size() != 0);
        quiet_tail = 1'b1;
        for (int i = 0; i < RANDOM_TAIL; i++) begin
            pending_reqs.push_back(random_req());
        end

        do begin
            @(posedge clk) #0.5;
        end while (pending_reqs.size() != 0 || in_valid || expected_resp.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d lookups, %0d inserts, %0d deletes, %0d unused-code items",
                 op_tally[FN_LOOKUP], op_tally[FN_INSERT], op_tally[FN_DELETE],
                 op_tally[FN_UNUSED]);
        $display("%0d results; %0d already-enabled, %0d no-memory; peak enabled count %0d",
                 results_seen, exists_seen, nomem_seen, peak_count);
        if (fail_count == 0 && expected_resp.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
